>>> rtl/core/thx_pkg.sv
// Shared types, constants and hex helpers for the tilde hex escape codec.
// No dependencies.
`default_nettype none

package thx_pkg;

  localparam logic [7:0] TILDE      = 8'h7E;
  localparam logic [7:0] PASS_LO    = 8'h20;
  localparam logic [7:0] PASS_HI    = 8'h7D;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [3:0] NIB_TEN    = 4'd10;
  localparam logic [4:0] HEX_BAD    = 5'd16;

  // configuration register indexes
  localparam logic       REG_MODE   = 1'b0;

  localparam logic       MODE_ENC   = 1'b0;
  localparam logic       MODE_DEC   = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TILDE = 2'd1,
    PH_HIGH  = 2'd2
  } phase_t;

  typedef logic [1:0] res_cnt_t;

  function automatic logic [7:0] hex_lower(input logic [3:0] v);
    logic [7:0] r;
    if (v < NIB_TEN) r = CH_0 + {4'd0, v};
    else             r = CH_LA + {4'd0, v - NIB_TEN};
    return r;
  endfunction

  // digit value, or HEX_BAD if not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + {4'd0, NIB_TEN};
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + {4'd0, NIB_TEN};
    end else begin
      d = {3'd0, HEX_BAD};
    end
    return d[4:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/thx_if.sv
// Valid/ready channel interfaces for the codec's input and result beats.
// No dependencies.
`default_nettype none

interface thx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface thx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       buffer_end;
  logic       decode_error;

  modport source (output valid, output out_byte, output run_last, output buffer_end,
                  output decode_error, input ready);
  modport sink   (input valid, input out_byte, input run_last, input buffer_end,
                  input decode_error, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tilde_hex_escape_codec.sv
// Top level of the tilde hex escape codec: decode state, result buffer, APB register.
// Depends on thx_pkg and the channel interfaces in thx_if.sv.
`default_nettype none

// Usage
//   in_if  : input beats (in_byte, in_last), accepted when valid && ready.
//   out_if : result beats (out_byte, run_last, buffer_end, decode_error).
//   cfg_*  : APB-style port, one register (mode) at address 0; pready tied high.
//            Write mode only while the codec is idle; a write clears decode state.
// Latency: a result beat is presented the cycle after its input beat is taken.
// Throughput: each input beat is converted in one pass into a three-entry result
//   buffer, which drains one beat per cycle while out_if.ready is high. Pass-through
//   and decoded bytes run at one input beat per cycle under that condition; an
//   escaped byte in encode mode waits on its three result beats. The next input beat
//   is taken while the final result beat of the previous one is being handed over.
// Decode beats that produce no result (a '~', a first digit, dropped bytes) leave
//   the buffer empty, so in_if.ready stays high.
// Stall: with the receiver holding ready low the buffer holds its beats and
//   in_if.ready stays low for as long as any result beat is waiting.
// Reset: synchronous, active low; mode returns to encode, decode state and the
//   buffer are cleared. No clearing pass is needed.

module tilde_hex_escape_codec (
  input  wire        clk,
  input  wire        rst_n,
  thx_in_if.sink     in_if,
  thx_out_if.source  out_if,
  input  wire        cfg_psel,
  input  wire        cfg_penable,
  input  wire        cfg_pwrite,
  input  wire [2:0]  cfg_paddr,
  input  wire [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);
  import thx_pkg::*;

  // register state
  logic       mode_r;
  phase_t     phase_r, phase_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic       disc_r, disc_nxt;

  // result buffer: slot 0 is the beat on show
  logic [7:0] slot_r [3];
  res_cnt_t   cnt_r;
  logic       be_r;
  logic       err_r;

  // per-beat conversion results
  res_cnt_t   res_cnt;
  logic [7:0] res_b [3];
  logic       res_be;
  logic       res_err;

  logic       accept, pop, cfg_wr_mode;
  logic [4:0] dig;

  // register index is the word address
  assign cfg_wr_mode = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                       (cfg_paddr[2] == REG_MODE);
  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = (cfg_paddr[2] == REG_MODE) ? {31'd0, mode_r} : 32'd0;

  // new beat may land as the last buffered beat leaves
  assign in_if.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_if.ready);
  assign accept      = in_if.valid && in_if.ready;
  assign pop         = out_if.valid && out_if.ready;
  assign dig         = hex_value(in_if.in_byte);

  // next decode state
  always_comb begin
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    disc_nxt  = disc_r;
    if (cfg_wr_mode) begin
      phase_nxt = PH_IDLE;
      hi_nxt    = 4'd0;
      disc_nxt  = 1'b0;
    end else if (accept && mode_r == MODE_DEC) begin
      if (disc_r) begin
        if (in_if.in_last) disc_nxt = 1'b0;
      end else begin
        unique case (phase_r) inside
          PH_TILDE, PH_HIGH: begin
            if (dig == HEX_BAD) begin
              phase_nxt = PH_IDLE;
              hi_nxt    = 4'd0;
              disc_nxt  = !in_if.in_last;
            end else if (phase_r == PH_TILDE) begin
              if (in_if.in_last) begin
                phase_nxt = PH_IDLE;
                hi_nxt    = 4'd0;
              end else begin
                phase_nxt = PH_HIGH;
                hi_nxt    = dig[3:0];
              end
            end else begin
              phase_nxt = PH_IDLE;
              hi_nxt    = 4'd0;
            end
          end
          default: begin
            // idle: a '~' opens an escape unless the buffer ends on it
            phase_nxt = PH_IDLE;
            if (in_if.in_byte == TILDE) begin
              if (in_if.in_last) hi_nxt = 4'd0;
              else               phase_nxt = PH_TILDE;
            end
          end
        endcase
      end
    end
  end

  // results of the beat on the input
  always_comb begin
    res_cnt  = 2'd0;
    res_b[0] = in_if.in_byte;
    res_b[1] = 8'd0;
    res_b[2] = 8'd0;
    res_be   = in_if.in_last;
    res_err  = 1'b0;
    if (mode_r == MODE_ENC) begin
      if (in_if.in_byte >= PASS_LO && in_if.in_byte <= PASS_HI) begin
        res_cnt = 2'd1;
      end else begin
        res_cnt  = 2'd3;
        res_b[0] = TILDE;
        res_b[1] = hex_lower(in_if.in_byte[7:4]);
        res_b[2] = hex_lower(in_if.in_byte[3:0]);
      end
    end else if (!disc_r) begin
      unique case (phase_r) inside
        PH_TILDE, PH_HIGH: begin
          if (dig == HEX_BAD || (phase_r == PH_TILDE && in_if.in_last)) begin
            res_cnt  = 2'd1;
            res_b[0] = 8'd0;
            res_be   = 1'b1;
            res_err  = 1'b1;
          end else if (phase_r == PH_HIGH) begin
            res_cnt  = 2'd1;
            res_b[0] = {hi_r, dig[3:0]};
          end
        end
        default: begin
          if (in_if.in_byte == TILDE) begin
            if (in_if.in_last) begin
              // buffer ends on a bare '~'
              res_cnt  = 2'd1;
              res_b[0] = 8'd0;
              res_be   = 1'b1;
              res_err  = 1'b1;
            end
          end else begin
            res_cnt = 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ENC;
      phase_r <= PH_IDLE;
      hi_r    <= 4'd0;
      disc_r  <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      if (cfg_wr_mode) mode_r <= cfg_pwdata[0];
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      disc_r  <= disc_nxt;
      if (accept)   cnt_r <= res_cnt;
      else if (pop) cnt_r <= cnt_r - 2'd1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r[0] <= res_b[0];
      slot_r[1] <= res_b[1];
      slot_r[2] <= res_b[2];
      be_r      <= res_be;
      err_r     <= res_err;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  assign out_if.valid        = (cnt_r != 2'd0);
  assign out_if.out_byte     = slot_r[0];
  assign out_if.run_last     = (cnt_r == 2'd1);
  assign out_if.buffer_end   = (cnt_r == 2'd1) && be_r;
  assign out_if.decode_error = err_r;

endmodule

`default_nettype wire

>>> rtl/core/thx_checker.sv
// Port-level checks for the tilde hex escape codec, bound to the top level.
// Depends on tilde_hex_escape_codec (bind target).
`default_nettype none

module thx_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       run_last,
  input wire       buffer_end,
  input wire       decode_error
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("result beat changed while stalled");

  // no new input beat while a stalled result is still pending
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && out_valid && !out_ready))
    else $error("input taken while output stalled");

  // buffer end only on the final beat of an input
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && buffer_end |-> run_last)
    else $error("buffer end without run last");

  // an error beat closes the buffer and carries zero
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && decode_error |-> run_last && buffer_end && (out_byte == 8'd0))
    else $error("malformed error beat");

endmodule

bind tilde_hex_escape_codec thx_checker u_thx_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_byte     (out_if.out_byte),
  .run_last     (out_if.run_last),
  .buffer_end   (out_if.buffer_end),
  .decode_error (out_if.decode_error)
);

`default_nettype wire
